// File: rtl/rgbmc_pkg.sv
// Shared types, constants and command bundle of the RGB565 frame mean colour unit.
package rgbmc_pkg;

    localparam int PIXEL_COUNT_BITS  = 20;
    localparam int FRACTION_BITS     = 8;
    localparam int OUT_W             = 5 + FRACTION_BITS;
    localparam int RED_SUM_W         = PIXEL_COUNT_BITS + 5;
    localparam int GREEN_SUM_W       = PIXEL_COUNT_BITS + 6;
    localparam int BLUE_SUM_W        = PIXEL_COUNT_BITS + 5;
    localparam int DIV_STEPS         = OUT_W + 1;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    localparam logic [PIXEL_COUNT_BITS-1:0] PIXEL_COUNT_RESET = PIXEL_COUNT_BITS'(76800);
    localparam logic [OUT_W-1:0] RB_MAX = OUT_W'(31 << FRACTION_BITS);
    localparam logic [OUT_W-1:0] G_MAX  = OUT_W'((63 << FRACTION_BITS) >> 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_W-1:0] red_mean;
        logic [OUT_W-1:0] green_mean;
        logic [OUT_W-1:0] blue_mean;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic byte_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

endpackage

// File: rtl/rgbmc_div_lane.sv
// Restoring divider lane: one quotient bit per step, saturated mean out.
module rgbmc_div_lane
    import rgbmc_pkg::*;
#(
    parameter int               SUM_W = RED_SUM_W,
    parameter int               DIV_W = PIXEL_COUNT_BITS,
    parameter logic [OUT_W-1:0] LIMIT = RB_MAX
)
(
    input  logic             clk,
    input  logic             start,
    input  logic             step,
    input  logic [SUM_W-1:0] sum,
    input  logic [DIV_W-1:0] divisor,
    output logic [OUT_W-1:0] mean
);

    localparam int DVD_W = SUM_W + FRACTION_BITS;
    localparam int SHD_W = DIV_W + OUT_W;
    localparam int W     = (DVD_W > SHD_W) ? DVD_W : SHD_W;

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dsr_reg;
    logic [OUT_W:0]   quo_reg;
    logic             ge;

    assign ge = (rem_reg >= dsr_reg);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= W'(sum) << FRACTION_BITS;
            dsr_reg <= W'(divisor) << OUT_W;
            quo_reg <= '0;
        end
        else if (step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= {quo_reg[OUT_W-1:0], ge};
        end
    end

    // top quotient bit set means the mean is off the scale; garbage below it
    assign mean = (quo_reg[OUT_W] || (quo_reg[OUT_W-1:0] > LIMIT)) ?
                  LIMIT : quo_reg[OUT_W-1:0];

endmodule

// File: rtl/rgbmc_datapath.sv
// Datapath: byte pairing, saturating sums, divider lanes, pixel count and result register.
module rgbmc_datapath
    import rgbmc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctrl_cmd_t                   cmd,
    input  in_beat_t                    in_data,
    input  logic                        cfg_we,
    input  logic [PIXEL_COUNT_BITS-1:0] cfg_data,
    output out_beat_t                   out_data
);

    logic                        phase_reg;
    logic [7:0]                  high_reg;
    logic [RED_SUM_W-1:0]        red_sum_reg;
    logic [GREEN_SUM_W-1:0]      green_sum_reg;
    logic [BLUE_SUM_W-1:0]       blue_sum_reg;
    logic [PIXEL_COUNT_BITS-1:0] pcount_reg;
    out_beat_t                   out_reg;

    logic [15:0]                 pix;
    logic [RED_SUM_W:0]          red_wide;
    logic [GREEN_SUM_W:0]        green_wide;
    logic [BLUE_SUM_W:0]         blue_wide;
    logic [RED_SUM_W-1:0]        red_sum_next;
    logic [GREEN_SUM_W-1:0]      green_sum_next;
    logic [BLUE_SUM_W-1:0]       blue_sum_next;
    logic [OUT_W-1:0]            red_q;
    logic [OUT_W-1:0]            green_q;
    logic [OUT_W-1:0]            blue_q;

    // RGB565: red in bits 15..11, green 10..5, blue 4..0
    assign pix        = {high_reg, in_data.pixel_byte};
    assign red_wide   = {1'b0, red_sum_reg}   + (RED_SUM_W + 1)'(pix[15:11]);
    assign green_wide = {1'b0, green_sum_reg} + (GREEN_SUM_W + 1)'(pix[10:5]);
    assign blue_wide  = {1'b0, blue_sum_reg}  + (BLUE_SUM_W + 1)'(pix[4:0]);

    always_comb
    begin
        red_sum_next   = red_sum_reg;
        green_sum_next = green_sum_reg;
        blue_sum_next  = blue_sum_reg;
        if (phase_reg)
        begin
            red_sum_next   = red_wide[RED_SUM_W]     ? '1 : red_wide[RED_SUM_W-1:0];
            green_sum_next = green_wide[GREEN_SUM_W] ? '1 : green_wide[GREEN_SUM_W-1:0];
            blue_sum_next  = blue_wide[BLUE_SUM_W]   ? '1 : blue_wide[BLUE_SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            high_reg      <= '0;
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            pcount_reg    <= PIXEL_COUNT_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                pcount_reg <= cfg_data;
            end
            if (cmd.byte_en)
            begin
                if (!phase_reg)
                begin
                    high_reg <= in_data.pixel_byte;
                end
                if (in_data.frame_end)
                begin
                    phase_reg     <= 1'b0;
                    red_sum_reg   <= '0;
                    green_sum_reg <= '0;
                    blue_sum_reg  <= '0;
                end
                else
                begin
                    phase_reg     <= ~phase_reg;
                    red_sum_reg   <= red_sum_next;
                    green_sum_reg <= green_sum_next;
                    blue_sum_reg  <= blue_sum_next;
                end
            end
        end
    end

    rgbmc_div_lane #(
        .SUM_W (RED_SUM_W),
        .DIV_W (PIXEL_COUNT_BITS),
        .LIMIT (RB_MAX)
    ) u_red (
        .clk     (clk),
        .start   (cmd.div_start),
        .step    (cmd.div_step),
        .sum     (red_sum_next),
        .divisor (pcount_reg),
        .mean    (red_q)
    );

    // green mean is halved: divide by twice the pixel count
    rgbmc_div_lane #(
        .SUM_W (GREEN_SUM_W),
        .DIV_W (PIXEL_COUNT_BITS + 1),
        .LIMIT (G_MAX)
    ) u_green (
        .clk     (clk),
        .start   (cmd.div_start),
        .step    (cmd.div_step),
        .sum     (green_sum_next),
        .divisor ({pcount_reg, 1'b0}),
        .mean    (green_q)
    );

    rgbmc_div_lane #(
        .SUM_W (BLUE_SUM_W),
        .DIV_W (PIXEL_COUNT_BITS),
        .LIMIT (RB_MAX)
    ) u_blue (
        .clk     (clk),
        .start   (cmd.div_start),
        .step    (cmd.div_step),
        .sum     (blue_sum_next),
        .divisor (pcount_reg),
        .mean    (blue_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.red_mean   <= red_q;
            out_reg.green_mean <= green_q;
            out_reg.blue_mean  <= blue_q;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/rgbmc_ctrl.sv
// Controller: accumulate / divide / hand-over state machine and output valid.
module rgbmc_ctrl
    import rgbmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      frame_end,
    input  logic      out_ready,
    output logic      in_ready,
    output logic      out_valid,
    output ctrl_cmd_t cmd
);

    state_t               state_reg;
    state_t               state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                cnt_next = '0;
                if (in_valid && frame_end)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_ACC:
            begin
                in_ready      = 1'b1;
                cmd.byte_en   = in_valid;
                cmd.div_start = in_valid && frame_end;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/rgb565_frame_mean_color_unit.sv
// Top level of the RGB565 frame mean colour unit: controller plus datapath.
//
//  channel   signals                        direction  beat contents
//  in        in_valid / in_ready / in_data  inbound    pixel_byte, frame_end
//  out       out_valid / out_ready/out_data outbound   red_mean, green_mean, blue_mean
//  cfg       cfg_valid / cfg_ready/cfg_data inbound    pixel_count (20 bits)
//
// Cycles: one input beat per cycle while a frame streams in. The beat that
// carries frame_end starts three parallel restoring dividers, one quotient
// bit per cycle; input is then held off while they run, and for
// as long again as the receiver leaves a previous result in the output register.
// The next frame may stream in while its result waits. Reset clears the sums, the
// byte phase and the output valid, and loads pixel_count with 76800. cfg is always ready.
module rgb565_frame_mean_color_unit
    import rgbmc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  in_beat_t                    in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output out_beat_t                   out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [PIXEL_COUNT_BITS-1:0] cfg_data
);

    ctrl_cmd_t cmd;

    // the pixel count register takes a write on any cycle
    assign cfg_ready = 1'b1;

    rgbmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (in_data.frame_end),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    rgbmc_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .out_data (out_data)
    );

endmodule

// File: tb/tb_rgb565_frame_mean_color_unit.sv
// Self-checking testbench for the RGB565 frame mean colour unit.
`timescale 1ns / 100ps

module tb_rgb565_frame_mean_color_unit;
    import rgbmc_pkg::*;

    // Run shape. Random frames are grouped into phases of roughly PHASE_BEATS beats.
    // Between phases the pixel count is rewritten.
    localparam int RANDOM_BEATS  = 1150;
    localparam int PHASE_BEATS   = 150;
    localparam int SETTLE_CYCLES = 24;     // lets the divider finish, plus margin
    localparam int LONG_HOLD     = 300;    // receiver hold-off while frames keep coming
    localparam int MAX_REPORTS   = 40;
    // The worst case is when every beat ends a frame and both sides stall their
    // longest, plus the long hold-off and the drains between phases.
    // Take that several times over.
    localparam int CYCLE_LIMIT   = 500_000;

    localparam logic [OUT_W-1:0] NO_MEAN = '0;
    localparam logic [PIXEL_COUNT_BITS-1:0] FULL_COUNT = '1;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [PIXEL_COUNT_BITS-1:0] cfg_data;

    // One row of the directed table. Where typed is set, want is the expected mean.
    // Otherwise the expected mean comes from the predictor.
    typedef struct packed {
        logic                        set_count;
        logic [PIXEL_COUNT_BITS-1:0] count;
        logic [7:0]                  pbyte;
        logic                        last;
        logic [21:0]                 reps;
        logic                        typed;
        out_beat_t                   want;
    } stim_row_t;

    stim_row_t stim_rows[$];

    // Predictor state: the pixel count in force and the running frame sums.
    logic [PIXEL_COUNT_BITS-1:0] div_count;
    logic                        half_pending;
    logic [7:0]                  held_high;
    logic [RED_SUM_W-1:0]        run_red;
    logic [GREEN_SUM_W-1:0]      run_green;
    logic [BLUE_SUM_W-1:0]       run_blue;

    out_beat_t pending_means[$];

    bit idle_on;
    bit hold_long_req;
    int fails;
    int beats_in;
    int means_checked;
    int count_writes;
    int cycle_count;

    rgb565_frame_mean_color_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Add a channel value to a running sum, holding it at the all-ones value of its width.
    function automatic longint unsigned sat_sum(input longint unsigned sum,
                                                input longint unsigned add,
                                                input int              w);
        longint unsigned lim;
        longint unsigned s;
        lim = (64'd1 << w) - 64'd1;
        s   = sum + add;
        return (s > lim) ? lim : s;
    endfunction

    // Truncated fixed-point quotient, clamped to the field maximum. A zero divisor
    // reads as all ones from the divider, so it clamps too.
    function automatic logic [OUT_W-1:0] scaled_mean(input longint unsigned sum,
                                                     input longint unsigned divisor,
                                                     input longint unsigned limit);
        longint unsigned q;
        if (divisor == 0)
            return OUT_W'(limit);
        q = (sum << FRACTION_BITS) / divisor;
        return (q > limit) ? OUT_W'(limit) : OUT_W'(q);
    endfunction

    // Fold one accepted beat into the frame sums. Return 1, with the means, on frame end.
    function automatic bit fold_byte(input logic [7:0] b, input logic last,
                                     output out_beat_t means);
        logic [15:0] pix;
        means = '0;
        if (!half_pending)
        begin
            held_high    = b;
            half_pending = 1'b1;
        end
        else
        begin
            pix          = {held_high, b};
            run_red      = RED_SUM_W'(sat_sum(run_red, pix[15:11], RED_SUM_W));
            run_green    = GREEN_SUM_W'(sat_sum(run_green, pix[10:5], GREEN_SUM_W));
            run_blue     = BLUE_SUM_W'(sat_sum(run_blue, pix[4:0], BLUE_SUM_W));
            half_pending = 1'b0;
        end
        if (!last)
            return 1'b0;
        // A lone high byte at frame end is dropped with the rest of the frame state.
        means.red_mean   = scaled_mean(run_red, div_count, RB_MAX);
        means.green_mean = scaled_mean(run_green, {div_count, 1'b0}, G_MAX);
        means.blue_mean  = scaled_mean(run_blue, div_count, RB_MAX);
        run_red      = '0;
        run_green    = '0;
        run_blue     = '0;
        half_pending = 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_row(input logic set_count,
                                    input logic [PIXEL_COUNT_BITS-1:0] count,
                                    input logic [7:0] pbyte, input logic last,
                                    input logic [21:0] reps, input logic typed,
                                    input out_beat_t want);
        stim_rows.push_back({set_count, count, pbyte, last, reps, typed, want});
    endfunction

    // Offer one beat from the falling edge and hold it until it is taken.
    // Queue the expected means on frame end.
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input bit typed, input out_beat_t typed_means);
        out_beat_t means;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        if (fold_byte(b, last, means))
            pending_means.push_back(typed ? typed_means : means);
        beats_in++;
    endtask

    // Drop valid, wait until every expected mean is back, then allow the divider to settle.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_means.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_pixel_count(input logic [PIXEL_COUNT_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        div_count = value;
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic report_field(input string name, input logic [OUT_W-1:0] want,
                                input logic [OUT_W-1:0] got);
        if (want !== got)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Receiver ready. Drop it in random bursts, or for one long hold-off on request.
    // Hold it high throughout once idling is switched off.
    initial
    begin : sink_ready_drive
        int hold_left;
        hold_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_long_req)
            begin
                hold_long_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                out_ready     <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result beat, field by field, with the oldest expected mean.
    initial
    begin : result_check
        out_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (pending_means.size() == 0)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: result beat with none expected, got %0d/%0d/%0d",
                                 $time, out_data.red_mean, out_data.green_mean,
                                 out_data.blue_mean);
                end
                else
                begin
                    want = pending_means.pop_front();
                    report_field("red_mean", want.red_mean, out_data.red_mean);
                    report_field("green_mean", want.green_mean, out_data.green_mean);
                    report_field("blue_mean", want.blue_mean, out_data.blue_mean);
                    means_checked++;
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out with %0d means outstanding", $time, pending_means.size());
        $display("rgb565_frame_mean_color_unit: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int          phase_no;
        int          random_beats;
        int          phase_beats;
        int          mode;
        int          n_pix;
        int          n_bytes;
        bit          last_phase;
        bit          match_len;
        bit          broken;
        bit          fill_ones;
        logic [PIXEL_COUNT_BITS-1:0] pc;
        logic [7:0]  b;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        idle_on       = 1'b0;
        hold_long_req = 1'b0;
        fails         = 0;
        beats_in      = 0;
        means_checked = 0;
        count_writes  = 0;

        // Predictor starts from the reset state: default pixel count, empty sums.
        div_count    = PIXEL_COUNT_RESET;
        half_pending = 1'b0;
        held_high    = '0;
        run_red      = '0;
        run_green    = '0;
        run_blue     = '0;

        //       set  count       byte   last reps  typed want
        // Reset pixel count: one white pixel and a lone high byte both average to zero.
        add_row(0, 0,          8'hFF, 0, 1, 0, '0);
        add_row(0, 0,          8'hFF, 1, 1, 1, {NO_MEAN, NO_MEAN, NO_MEAN});
        add_row(0, 0,          8'hAB, 1, 1, 1, {NO_MEAN, NO_MEAN, NO_MEAN});
        // Count of one: white gives every field its maximum.
        add_row(1, 1,          8'hFF, 0, 1, 0, '0);
        add_row(0, 0,          8'hFF, 1, 1, 1, {RB_MAX, G_MAX, RB_MAX});
        // Two full-red pixels over a count of one: red clamps.
        add_row(0, 0,          8'hF8, 0, 1, 0, '0);
        add_row(0, 0,          8'h00, 0, 1, 0, '0);
        add_row(0, 0,          8'hF8, 0, 1, 0, '0);
        add_row(0, 0,          8'h00, 1, 1, 1, {RB_MAX, NO_MEAN, NO_MEAN});
        // Full green, then frame end on a trailing high byte that must be dropped.
        add_row(0, 0,          8'h07, 0, 1, 0, '0);
        add_row(0, 0,          8'hE0, 0, 1, 0, '0);
        add_row(0, 0,          8'h55, 1, 1, 1, {NO_MEAN, G_MAX, NO_MEAN});
        add_row(0, 0,          8'h00, 0, 1, 0, '0);
        add_row(0, 0,          8'h1F, 1, 1, 1, {NO_MEAN, NO_MEAN, RB_MAX});
        // Count of zero: the divider answers all ones, so every mean clamps.
        add_row(1, 0,          8'h12, 0, 1, 0, '0);
        add_row(0, 0,          8'h34, 1, 1, 1, {RB_MAX, G_MAX, RB_MAX});
        add_row(0, 0,          8'h00, 1, 1, 1, {RB_MAX, G_MAX, RB_MAX});
        // Mixed pixels, checked against the predictor.
        add_row(1, 3,          8'h84, 0, 1, 0, '0);
        add_row(0, 0,          8'h10, 0, 1, 0, '0);
        add_row(0, 0,          8'hA5, 0, 1, 0, '0);
        add_row(0, 0,          8'h5A, 1, 1, 0, '0);
        add_row(1, 2,          8'h7B, 0, 1, 0, '0);
        add_row(0, 0,          8'hEF, 0, 1, 0, '0);
        add_row(0, 0,          8'h3C, 1, 1, 0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling. Rewrite the count only once the block has drained.
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].set_count)
            begin
                drain_results();
                write_pixel_count(stim_rows[i].count);
            end
            for (int n = 1; n < stim_rows[i].reps; n++)
                push_byte(stim_rows[i].pbyte, 1'b0, 1'b0, '0);
            push_byte(stim_rows[i].pbyte, stim_rows[i].last, stim_rows[i].typed,
                      stim_rows[i].want);
        end

        // Random frames, phase by phase. Each phase opens with the sender paused until
        // every expected mean has come back, then a new pixel count.
        phase_no     = 0;
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            drain_results();
            last_phase = (random_beats + PHASE_BEATS >= RANDOM_BEATS);
            idle_on    = !last_phase;
            match_len  = 1'b0;
            mode       = (phase_no == 0) ? 0 : $urandom_range(0, 7);
            case (mode)
                0:       pc = $urandom_range(1, 8);
                1:       pc = $urandom_range(9, 64);
                2:       pc = $urandom_range(1, (1 << PIXEL_COUNT_BITS) - 1);
                3:       pc = '0;
                4:       pc = FULL_COUNT;
                default:
                begin
                    // Frames of exactly pc pixels: the intended use.
                    pc        = $urandom_range(1, 24);
                    match_len = 1'b1;
                end
            endcase
            write_pixel_count(pc);
            // Third phase: hold the receiver off while short frames keep arriving,
            // so the result register and divider fill and input stalls.
            if (phase_no == 2)
                hold_long_req = 1'b1;

            phase_beats = 0;
            while (phase_beats < PHASE_BEATS)
            begin
                broken    = ($urandom_range(0, 6) == 0);
                fill_ones = ($urandom_range(0, 4) == 0);
                if (match_len && !broken)
                    n_pix = pc;
                else if (phase_no == 2)
                    n_pix = $urandom_range(1, 3);
                else
                    n_pix = $urandom_range(1, 24);
                if (broken && $urandom_range(0, 3) == 0)
                    n_pix = 0;
                n_bytes = 2 * n_pix + (broken ? 1 : 0);
                for (int k = 0; k < n_bytes; k++)
                begin
                    b = fill_ones ? 8'hFF : 8'($urandom);
                    push_byte(b, k == n_bytes - 1, 1'b0, '0);
                end
                phase_beats += n_bytes;
            end
            random_beats += phase_beats;
            phase_no++;
        end

        drain_results();

        $display("Run covered %0d input beats and %0d frame means over %0d pixel count writes",
                 beats_in, means_checked, count_writes);
        $display("Covered zero, one and full-scale counts, clamped means, odd trailing bytes");
        $display("and a long output hold-off that stalls the input");
        if (fails == 0)
            $display("rgb565_frame_mean_color_unit: match");
        else
            $display("rgb565_frame_mean_color_unit: mismatch");
        $finish;
    end

endmodule

// File: rgb565_frame_mean_color_unit.f
rtl/rgbmc_pkg.sv
rtl/rgbmc_div_lane.sv
rtl/rgbmc_datapath.sv
rtl/rgbmc_ctrl.sv
rtl/rgb565_frame_mean_color_unit.sv
tb/tb_rgb565_frame_mean_color_unit.sv
